// ===== src/mc_pkg.sv =====
// ----------------------------------------------------------------------------
// mc_pkg: shared types and constants of the maze carver
// Grid limits, derived widths, transfer types, register indexes, sequencer
// states and the draw reduction helper.
// ----------------------------------------------------------------------------
package mc_pkg;

    localparam int MAX_CELL_ROWS = 32;
    localparam int MAX_CELL_COLS = 64;

    // cell index widths and count widths (count holds the maximum itself)
    localparam int ROW_W  = (MAX_CELL_ROWS > 1) ? $clog2(MAX_CELL_ROWS) : 1;
    localparam int COL_W  = (MAX_CELL_COLS > 1) ? $clog2(MAX_CELL_COLS) : 1;
    localparam int RCNT_W = ROW_W + 1;
    localparam int CCNT_W = COL_W + 1;

    localparam int CELL_ROWS_W = 6;
    localparam int CELL_COLS_W = 7;
    localparam int WALL_ROW_W  = 6;
    localparam int WALL_COL_W  = 7;
    localparam int DRAW_W      = 8;

    localparam logic [CELL_ROWS_W-1:0] CELL_ROWS_RESET = CELL_ROWS_W'(10);
    localparam logic [CELL_COLS_W-1:0] CELL_COLS_RESET = CELL_COLS_W'(39);

    localparam logic [MAX_CELL_COLS-1:0] ROW_BIT0 = MAX_CELL_COLS'(1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_ROWS = 1'b0,
        CFG_CELL_COLS = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [DRAW_W-1:0] draw;
        logic              restart;
    } in_item_t;

    typedef struct packed {
        logic [WALL_ROW_W-1:0] wall_row;
        logic [WALL_COL_W-1:0] wall_col;
        logic                  carved;
        logic                  finished;
    } out_item_t;

    // neighbor order used for candidate gathering
    typedef enum logic [1:0] {
        DIR_DOWN  = 2'd0,
        DIR_UP    = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RD_UP,
        ST_RD_DN,
        ST_RD_MID,
        ST_EVAL,
        ST_WR_MID,
        ST_WR_NB,
        ST_FLUSH
    } state_t;

    // draw mod n for n in 1..4; mod 3 sums base-4 digits since 4 == 1 mod 3
    function automatic logic [1:0] pick_index(input logic [DRAW_W-1:0] d,
                                              input logic [2:0] n);
        logic [3:0] s;
        logic [1:0] m3;
        begin
            s = {2'b00, d[1:0]} + {2'b00, d[3:2]} + {2'b00, d[5:4]} + {2'b00, d[7:6]};
            if (s >= 4'd12)
                m3 = 2'd0;
            else if (s >= 4'd9)
                m3 = 2'(s - 4'd9);
            else if (s >= 4'd6)
                m3 = 2'(s - 4'd6);
            else if (s >= 4'd3)
                m3 = 2'(s - 4'd3);
            else
                m3 = s[1:0];
            unique case (n)
                3'd2:    pick_index = {1'b0, d[0]};
                3'd3:    pick_index = m3;
                3'd4:    pick_index = d[1:0];
                default: pick_index = 2'd0;
            endcase
        end
    endfunction

endpackage

// ===== src/maze_carver_core.sv =====
// ----------------------------------------------------------------------------
// maze_carver_core: hunt-and-kill maze carver
// Each input transfer carries one random draw and yields one result: the
// wall that was opened, or the finished flag once the whole grid is carved.
// ----------------------------------------------------------------------------
// One item at a time. Every cell the sequencer examines passes through one
// range check, three row reads of the visited memory through its read port,
// one evaluate step and one row write, plus one more write when the carve
// goes vertical; then a hand-off state loads the output register once it is
// free, and the idle state takes the next draw. When the walk dead-ends the
// anchor scan passes over finished cells before a draw is used, so an item
// can take much longer than a carve from the walk cell. The visited map is
// one row per memory word with a valid flop per row: reset and restart clear
// it at once, no clearing pass.
module maze_carver_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  mc_pkg::in_item_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output mc_pkg::out_item_t                   out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    mc_pkg::state_t state_reg, state_next;

    logic [mc_pkg::CELL_ROWS_W-1:0] cell_rows_reg;
    logic [mc_pkg::CELL_COLS_W-1:0] cell_cols_reg;
    logic [mc_pkg::RCNT_W-1:0]      rows_eff;
    logic [mc_pkg::CCNT_W-1:0]      cols_eff;

    logic [mc_pkg::ROW_W-1:0]  walk_row_reg, anchor_row_reg, cur_row_reg;
    logic [mc_pkg::COL_W-1:0]  walk_col_reg, anchor_col_reg, cur_col_reg;
    logic                      walking_reg, again_reg, done_reg;
    logic [mc_pkg::DRAW_W-1:0] draw_reg;

    logic [mc_pkg::MAX_CELL_COLS-1:0] up_reg, dn_reg, mid_reg;
    logic                             none_reg, multi_reg;
    mc_pkg::dir_t                     sel_reg;

    mc_pkg::out_item_t res_reg, out_data_reg;
    logic              out_valid_reg;

    // visited memory
    logic [mc_pkg::MAX_CELL_COLS-1:0] vis_mem [mc_pkg::MAX_CELL_ROWS];
    logic [mc_pkg::MAX_CELL_ROWS-1:0] row_vld_reg;
    logic [mc_pkg::MAX_CELL_COLS-1:0] rd_q, rd_eff, wr_data;
    logic                             rd_vld_q, rd_en, wr_en, load_out;
    logic [mc_pkg::ROW_W-1:0]         rd_addr, wr_addr;

    // ------------------------------------------------------------------
    // effective grid size
    always_comb
    begin
        if (cell_rows_reg == '0)
            rows_eff = mc_pkg::RCNT_W'(1);
        else if (int'(cell_rows_reg) > mc_pkg::MAX_CELL_ROWS)
            rows_eff = mc_pkg::RCNT_W'(mc_pkg::MAX_CELL_ROWS);
        else
            rows_eff = mc_pkg::RCNT_W'(cell_rows_reg);
        if (cell_cols_reg == '0)
            cols_eff = mc_pkg::CCNT_W'(1);
        else if (int'(cell_cols_reg) > mc_pkg::MAX_CELL_COLS)
            cols_eff = mc_pkg::CCNT_W'(mc_pkg::MAX_CELL_COLS);
        else
            cols_eff = mc_pkg::CCNT_W'(cell_cols_reg);
    end

    // ------------------------------------------------------------------
    // range checks and anchor advance
    logic                      walk_out, anchor_row_out, anchor_col_out;
    logic [mc_pkg::CCNT_W-1:0] col_inc;
    logic [mc_pkg::RCNT_W-1:0] row_inc, adv_row_ext;
    logic                      adv_wrap, adv_done;
    logic [mc_pkg::ROW_W-1:0]  adv_row;
    logic [mc_pkg::COL_W-1:0]  adv_col;

    assign walk_out = ({1'b0, walk_row_reg} >= rows_eff) || ({1'b0, walk_col_reg} >= cols_eff);
    assign anchor_row_out = {1'b0, anchor_row_reg} >= rows_eff;
    assign anchor_col_out = {1'b0, anchor_col_reg} >= cols_eff;

    assign col_inc     = {1'b0, anchor_col_reg} + mc_pkg::CCNT_W'(1);
    assign row_inc     = {1'b0, anchor_row_reg} + mc_pkg::RCNT_W'(1);
    assign adv_wrap    = col_inc >= cols_eff;
    assign adv_row_ext = adv_wrap ? row_inc : {1'b0, anchor_row_reg};
    assign adv_done    = adv_row_ext >= rows_eff;
    assign adv_row     = adv_row_ext[mc_pkg::ROW_W-1:0];
    assign adv_col     = adv_wrap ? '0 : col_inc[mc_pkg::COL_W-1:0];

    // ------------------------------------------------------------------
    // neighbor evaluation
    logic [mc_pkg::RCNT_W-1:0] cur_row_inc;
    logic [mc_pkg::CCNT_W-1:0] cur_col_inc;
    logic [mc_pkg::COL_W-1:0]  col_p1, col_m1;
    logic [mc_pkg::ROW_W-1:0]  row_p1, row_m1;
    logic [3:0]                cand;
    logic [2:0]                n_cand;
    logic [1:0]                pick;
    mc_pkg::dir_t              sel;

    assign rd_eff      = rd_q & {mc_pkg::MAX_CELL_COLS{rd_vld_q}};
    assign cur_row_inc = {1'b0, cur_row_reg} + mc_pkg::RCNT_W'(1);
    assign cur_col_inc = {1'b0, cur_col_reg} + mc_pkg::CCNT_W'(1);
    assign row_p1      = cur_row_inc[mc_pkg::ROW_W-1:0];
    assign col_p1      = cur_col_inc[mc_pkg::COL_W-1:0];
    assign row_m1      = cur_row_reg - mc_pkg::ROW_W'(1);
    assign col_m1      = cur_col_reg - mc_pkg::COL_W'(1);

    always_comb
    begin
        cand[mc_pkg::DIR_DOWN]  = (cur_row_inc < rows_eff) && !dn_reg[cur_col_reg];
        cand[mc_pkg::DIR_UP]    = (cur_row_reg != '0) && !up_reg[cur_col_reg];
        cand[mc_pkg::DIR_RIGHT] = (cur_col_inc < cols_eff) && !rd_eff[col_p1];
        cand[mc_pkg::DIR_LEFT]  = (cur_col_reg != '0) && !rd_eff[col_m1];
        n_cand = {2'b00, cand[0]} + {2'b00, cand[1]} + {2'b00, cand[2]} + {2'b00, cand[3]};
    end

    assign pick = mc_pkg::pick_index(draw_reg, n_cand);

    // k-th set candidate in neighbor order
    always_comb
    begin
        logic [2:0] cnt;
        cnt = '0;
        sel = mc_pkg::DIR_DOWN;
        for (int i = 0; i < 4; i++)
        begin
            if (cand[i] && (cnt == {1'b0, pick}))
                sel = mc_pkg::dir_t'(i);
            cnt = cnt + {2'b00, cand[i]};
        end
    end

    // chosen cell and opened wall
    logic [mc_pkg::ROW_W-1:0]  nr;
    logic [mc_pkg::COL_W-1:0]  nc;
    logic [mc_pkg::RCNT_W:0]   wall_r_sum;
    logic [mc_pkg::CCNT_W:0]   wall_c_sum;
    logic                      sel_vert;

    always_comb
    begin
        nr = cur_row_reg;
        nc = cur_col_reg;
        unique case (sel_reg)
            mc_pkg::DIR_DOWN:  nr = row_p1;
            mc_pkg::DIR_UP:    nr = row_m1;
            mc_pkg::DIR_RIGHT: nc = col_p1;
            mc_pkg::DIR_LEFT:  nc = col_m1;
            default:           nr = cur_row_reg;
        endcase
    end

    assign sel_vert   = (sel_reg == mc_pkg::DIR_DOWN) || (sel_reg == mc_pkg::DIR_UP);
    assign wall_r_sum = {2'b00, cur_row_reg} + {2'b00, nr} + (mc_pkg::RCNT_W + 1)'(1);
    assign wall_c_sum = {2'b00, cur_col_reg} + {2'b00, nc} + (mc_pkg::CCNT_W + 1)'(1);

    // ------------------------------------------------------------------
    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mc_pkg::ST_IDLE:
                if (in_valid)
                    state_next = mc_pkg::ST_CHECK;
            mc_pkg::ST_CHECK:
            begin
                priority if (done_reg)
                    state_next = mc_pkg::ST_FLUSH;
                else if (walking_reg && walk_out)
                    state_next = mc_pkg::ST_CHECK;
                else if (!walking_reg && anchor_row_out)
                    state_next = mc_pkg::ST_FLUSH;
                else if (!walking_reg && anchor_col_out)
                    state_next = mc_pkg::ST_CHECK;
                else
                    state_next = mc_pkg::ST_RD_UP;
            end
            mc_pkg::ST_RD_UP:  state_next = mc_pkg::ST_RD_DN;
            mc_pkg::ST_RD_DN:  state_next = mc_pkg::ST_RD_MID;
            mc_pkg::ST_RD_MID: state_next = mc_pkg::ST_EVAL;
            mc_pkg::ST_EVAL:   state_next = mc_pkg::ST_WR_MID;
            mc_pkg::ST_WR_MID:
            begin
                priority if (none_reg)
                    state_next = mc_pkg::ST_CHECK;
                else if (sel_vert)
                    state_next = mc_pkg::ST_WR_NB;
                else
                    state_next = mc_pkg::ST_FLUSH;
            end
            mc_pkg::ST_WR_NB:  state_next = mc_pkg::ST_FLUSH;
            mc_pkg::ST_FLUSH:
                if (!out_valid_reg || !out_stall)
                    state_next = mc_pkg::ST_IDLE;
            default:           state_next = mc_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // control outputs
    always_comb
    begin
        in_stall = 1'b1;
        rd_en    = 1'b0;
        rd_addr  = cur_row_reg;
        wr_en    = 1'b0;
        wr_addr  = cur_row_reg;
        wr_data  = mid_reg | (mc_pkg::ROW_BIT0 << cur_col_reg);
        load_out = 1'b0;
        unique case (state_reg)
            mc_pkg::ST_IDLE:   in_stall = 1'b0;
            mc_pkg::ST_RD_UP:
            begin
                rd_en   = 1'b1;
                rd_addr = row_m1;
            end
            mc_pkg::ST_RD_DN:
            begin
                rd_en   = 1'b1;
                rd_addr = row_p1;
            end
            mc_pkg::ST_RD_MID: rd_en = 1'b1;
            mc_pkg::ST_WR_MID:
            begin
                wr_en = 1'b1;
                if (!none_reg && !sel_vert)
                    wr_data = mid_reg | (mc_pkg::ROW_BIT0 << cur_col_reg)
                            | (mc_pkg::ROW_BIT0 << nc);
            end
            mc_pkg::ST_WR_NB:
            begin
                wr_en   = 1'b1;
                wr_addr = nr;
                wr_data = ((sel_reg == mc_pkg::DIR_DOWN) ? dn_reg : up_reg)
                        | (mc_pkg::ROW_BIT0 << nc);
            end
            mc_pkg::ST_FLUSH:  load_out = !out_valid_reg || !out_stall;
            default:           in_stall = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // visited memory, one row per word
    always_ff @(posedge clk)
    begin
        if (wr_en)
            vis_mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_q     <= vis_mem[rd_addr];
            rd_vld_q <= row_vld_reg[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mc_pkg::ST_IDLE;
            cell_rows_reg <= mc_pkg::CELL_ROWS_RESET;
            cell_cols_reg <= mc_pkg::CELL_COLS_RESET;
            walk_row_reg  <= '0;
            walk_col_reg  <= '0;
            anchor_row_reg <= '0;
            anchor_col_reg <= '0;
            walking_reg   <= 1'b0;
            again_reg     <= 1'b0;
            done_reg      <= 1'b0;
            row_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                unique case (mc_pkg::cfg_idx_t'(cfg_index))
                    mc_pkg::CFG_CELL_ROWS: cell_rows_reg <= cfg_wdata[mc_pkg::CELL_ROWS_W-1:0];
                    mc_pkg::CFG_CELL_COLS: cell_cols_reg <= cfg_wdata[mc_pkg::CELL_COLS_W-1:0];
                    default:               cell_rows_reg <= cell_rows_reg;
                endcase
            end

            if (wr_en)
                row_vld_reg[wr_addr] <= 1'b1;

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                mc_pkg::ST_IDLE:
                    if (in_valid && in_data.restart)
                    begin
                        row_vld_reg    <= '0;
                        walk_row_reg   <= '0;
                        walk_col_reg   <= '0;
                        anchor_row_reg <= '0;
                        anchor_col_reg <= '0;
                        walking_reg    <= 1'b0;
                        again_reg      <= 1'b0;
                        done_reg       <= 1'b0;
                    end
                mc_pkg::ST_CHECK:
                begin
                    priority if (done_reg)
                        done_reg <= 1'b1;
                    else if (walking_reg && walk_out)
                    begin
                        walking_reg <= 1'b0;
                        if (!again_reg)
                        begin
                            again_reg      <= 1'b0;
                            anchor_row_reg <= adv_row;
                            anchor_col_reg <= adv_col;
                            done_reg       <= adv_done;
                        end
                    end
                    else if (!walking_reg && anchor_row_out)
                        done_reg <= 1'b1;
                    else if (!walking_reg && anchor_col_out)
                    begin
                        again_reg      <= 1'b0;
                        anchor_row_reg <= adv_row;
                        anchor_col_reg <= adv_col;
                        done_reg       <= adv_done;
                    end
                end
                mc_pkg::ST_WR_MID:
                begin
                    if (none_reg)
                    begin
                        walking_reg <= 1'b0;
                        if (!walking_reg || !again_reg)
                        begin
                            again_reg      <= 1'b0;
                            anchor_row_reg <= adv_row;
                            anchor_col_reg <= adv_col;
                            done_reg       <= adv_done;
                        end
                    end
                    else
                    begin
                        if (!walking_reg)
                            again_reg <= multi_reg;
                        walk_row_reg <= nr;
                        walk_col_reg <= nc;
                        walking_reg  <= 1'b1;
                    end
                end
                default:
                    done_reg <= done_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    always_ff @(posedge clk)
    begin
        if (load_out)
            out_data_reg <= res_reg;
        unique case (state_reg)
            mc_pkg::ST_IDLE:
                if (in_valid)
                    draw_reg <= in_data.draw;
            mc_pkg::ST_CHECK:
            begin
                cur_row_reg <= walking_reg ? walk_row_reg : anchor_row_reg;
                cur_col_reg <= walking_reg ? walk_col_reg : anchor_col_reg;
                res_reg     <= '{wall_row: '0, wall_col: '0, carved: 1'b0, finished: 1'b1};
            end
            mc_pkg::ST_RD_DN:  up_reg <= rd_eff;
            mc_pkg::ST_RD_MID: dn_reg <= rd_eff;
            mc_pkg::ST_EVAL:
            begin
                mid_reg   <= rd_eff;
                none_reg  <= (n_cand == 3'd0);
                multi_reg <= (n_cand > 3'd1);
                sel_reg   <= sel;
            end
            mc_pkg::ST_WR_MID:
                res_reg <= '{wall_row: mc_pkg::WALL_ROW_W'(wall_r_sum),
                             wall_col: mc_pkg::WALL_COL_W'(wall_c_sum),
                             carved:   1'b1,
                             finished: 1'b0};
            default:
                res_reg <= res_reg;
        endcase
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is in work");

    a_carve_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.carved |->
            !out_data.finished && (out_data.wall_row[0] ^ out_data.wall_col[0]))
        else $error("opened wall is not between two adjacent cells");

    a_result_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == mc_pkg::ST_FLUSH))
        else $error("result appeared outside the hand-off state");
`endif

endmodule
